/* rtl/xfpar_pkg.sv */
`timescale 1ns / 1ps

package xfpar_pkg;

  // Longest payload accepted; a larger length byte drops the frame.
  localparam logic [7:0] MAX_PAYLOAD = 8'd120;

  // Reply frame: start, command, length, flag, checksum, end.
  localparam logic [2:0] REPLY_LAST_IDX = 3'd5;
  localparam logic [7:0] REPLY_LEN_BYTE = 8'h01;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [1:0] CFG_END_BYTE    = 2'd1;
  localparam logic [1:0] CFG_ACK_COMMAND = 2'd2;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_PAY  = 3'd3,
    PH_SUM  = 3'd4,
    PH_END  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NACK = 2'd2
  } kind_t;

  // Outcome of the byte currently offered to the parser.
  typedef struct packed {
    logic reply;   // six-byte reply frame to send
    logic flag;    // reply flag: 1 ack, 0 nack
    logic ack;     // ack received
    logic nack;    // nack received
  } xfpar_verdict_t;

  function automatic logic [7:0] reply_byte(
    input logic [2:0] idx,
    input logic       flag,
    input logic [7:0] start_byte,
    input logic [7:0] ack_command,
    input logic [7:0] end_byte
  );
    logic [7:0] b;
    case (idx)
      3'd0:    b = start_byte;
      3'd1:    b = ack_command;
      3'd2:    b = REPLY_LEN_BYTE;
      3'd3:    b = {7'd0, flag};
      3'd4:    b = ack_command ^ REPLY_LEN_BYTE ^ {7'd0, flag};
      default: b = end_byte;
    endcase
    return b;
  endfunction

endpackage

/* rtl/xor_framed_packet_ack_receiver.sv */
`timescale 1ns / 1ps

// Channel  | dir | handshake          | payload
// ---------+-----+--------------------+----------------------------------------
// in_      | in  | in_tvalid/tready   | tdata[7:0] rx_byte
// out_     | out | out_tvalid/tready  | tdata[7:0] tx_byte, [15:8] acked_count;
//          |     |                    | tuser[1:0] kind; tlast last
// cfg_     | in  | cfg_we             | cfg_index: 0 start, 1 end, 2 ack command
//
// An accepted item is held in the input register and is parsed from there
// into the output register. Bytes that close no frame are taken one per
// cycle, back to back, while no reply is streaming. A closing byte holds the
// input until the output register is empty; a reply then streams six items,
// one per cycle as out_tready allows, and the parser waits on the reply
// sequencer meanwhile.
// rst_n is synchronous; it clears the frame phase, ack count and valid flags,
// and loads the configuration defaults (start 0x02, end 0x03, ack 0x06).

module xor_framed_packet_ack_receiver
  import xfpar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] tx_byte, [15:8] acked_count
  output logic [1:0]  out_tuser,   // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration registers
  logic [7:0] start_r, end_r, ackcmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= 8'h02;
      end_r    <= 8'h03;
      ackcmd_r <= 8'h06;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE:  start_r  <= cfg_data;
        CFG_END_BYTE:    end_r    <= cfg_data;
        CFG_ACK_COMMAND: ackcmd_r <= cfg_data;
        default: ;  // index beyond the list is ignored
      endcase
    end
  end

  // input register
  logic       rx_v_r;
  logic [7:0] rx_r;

  // output register
  logic       out_v_r;
  kind_t      out_kind_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [7:0] out_cnt_r;

  // reply sequencer: bytes 1..5 after the parser loads byte 0
  logic       seq_busy_r;
  logic [2:0] seq_idx_r;
  logic       seq_flag_r;

  xfpar_verdict_t verdict;
  logic [7:0]     acked_now, acked_after;
  logic           produces, parse_go, out_free;

  assign produces  = verdict.reply | verdict.ack | verdict.nack;
  assign out_free  = !out_v_r || out_tready;
  // a result-bearing byte waits for an empty output register, so out_tready
  // never reaches in_tready combinationally
  assign parse_go  = rx_v_r && !seq_busy_r && (!produces || !out_v_r);
  assign in_tready = !rx_v_r || parse_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_v_r <= 1'b0;
    end else if (in_tready) begin
      rx_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      rx_r <= in_tdata;
    end
  end

  xfpar_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (parse_go),
    .rx_byte     (rx_r),
    .start_byte  (start_r),
    .end_byte    (end_r),
    .ack_command (ackcmd_r),
    .verdict     (verdict),
    .acked_now   (acked_now),
    .acked_after (acked_after)
  );

  // output register and sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      seq_busy_r <= 1'b0;
      seq_idx_r  <= '0;
    end else if (seq_busy_r) begin
      if (out_free) begin
        out_v_r    <= 1'b1;
        seq_idx_r  <= seq_idx_r + 3'd1;
        seq_busy_r <= (seq_idx_r != REPLY_LAST_IDX);
      end
    end else if (parse_go && produces) begin
      out_v_r    <= 1'b1;
      seq_busy_r <= verdict.reply;
      seq_idx_r  <= 3'd1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (seq_busy_r) begin
      if (out_free) begin
        out_kind_r <= KIND_TX;
        out_byte_r <= reply_byte(seq_idx_r, seq_flag_r, start_r, ackcmd_r, end_r);
        out_last_r <= (seq_idx_r == REPLY_LAST_IDX);
        out_cnt_r  <= acked_now;
      end
    end else if (parse_go && produces) begin
      seq_flag_r <= verdict.flag;
      out_cnt_r  <= acked_after;
      if (verdict.reply) begin
        out_kind_r <= KIND_TX;
        out_byte_r <= reply_byte(3'd0, verdict.flag, start_r, ackcmd_r, end_r);
        out_last_r <= 1'b0;
      end else begin
        out_kind_r <= verdict.ack ? KIND_ACK : KIND_NACK;
        out_byte_r <= ZERO_BYTE;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_cnt_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/xfpar_parser.sv */
`timescale 1ns / 1ps

module xfpar_parser
  import xfpar_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,          // consume rx_byte this cycle
  input  logic [7:0]     rx_byte,
  input  logic [7:0]     start_byte,
  input  logic [7:0]     end_byte,
  input  logic [7:0]     ack_command,
  output xfpar_verdict_t verdict,       // valid whenever rx_byte is offered
  output logic [7:0]     acked_now,     // ack count before this byte
  output logic [7:0]     acked_after    // ack count after this byte
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       sum_ok_r, sum_ok_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] cnt_r;

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    xor_nxt    = xor_r;
    sum_ok_nxt = sum_ok_r;
    first_nxt  = first_r;
    verdict    = '0;
    unique case (phase_r)
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        xor_nxt   = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        seen_nxt  = ZERO_BYTE;
        first_nxt = ZERO_BYTE;
        if (rx_byte > MAX_PAYLOAD) begin
          phase_nxt = PH_WAIT;
        end else if (rx_byte == ZERO_BYTE) begin
          phase_nxt = PH_SUM;
        end else begin
          phase_nxt = PH_PAY;
        end
      end
      PH_PAY: begin
        if (seen_r == ZERO_BYTE) begin
          first_nxt = rx_byte;
        end
        xor_nxt  = xor_r ^ rx_byte;
        seen_nxt = seen_r + 8'd1;
        if (seen_nxt >= len_r) begin
          phase_nxt = PH_SUM;
        end
      end
      PH_SUM: begin
        sum_ok_nxt = (rx_byte == xor_r);
        phase_nxt  = PH_END;
      end
      PH_END: begin
        phase_nxt = PH_WAIT;
        if (rx_byte == end_byte) begin
          if (!sum_ok_r) begin
            verdict.reply = 1'b1;
          end else if (cmd_r == ack_command) begin
            if (len_r != ZERO_BYTE && first_r == 8'd1) begin
              verdict.ack = 1'b1;
            end else begin
              verdict.nack = 1'b1;
            end
          end else begin
            verdict.reply = 1'b1;
            verdict.flag  = 1'b1;
          end
        end
      end
      default: begin
        // waiting for a start byte; unused codes behave the same
        if (rx_byte == start_byte) begin
          xor_nxt   = ZERO_BYTE;
          phase_nxt = PH_CMD;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
    endcase
  end

  assign acked_now   = cnt_r;
  assign acked_after = cnt_r + {7'd0, verdict.ack};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= acked_after;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
      xor_r    <= xor_nxt;
      sum_ok_r <= sum_ok_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import xfpar_pkg::*;

  // Run length guard, in clock cycles, set far above the slowest correct run
  // (every byte waiting out sender gaps, six-item replies under receiver
  // stalls, one long receiver hold-off).
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 12;

  // Hand-picked opening stream under the reset configuration
  // (start 0x02, end 0x03, ack command 0x06), first byte in the top bits.
  localparam int OPENING_LEN = 30;
  localparam logic [8*OPENING_LEN-1:0] OPENING = {
    8'h00,                               // stray byte outside a frame
    8'h02, 8'h06, 8'h01, 8'h01, 8'h06, 8'h03, // ack frame, first payload 1
    8'h02, 8'h06, 8'h00, 8'h06, 8'h03,   // zero-length ack frame -> nack
    8'h02, 8'hFF, 8'h00, 8'hFF, 8'h03,   // other good frame -> ack reply
    8'h02, 8'h80, 8'h00, 8'h55, 8'h03,   // checksum mismatch -> nack reply
    8'h02, 8'h11, 8'h79,                 // length 121, dropped at once
    8'h02, 8'h11, 8'h00, 8'h11, 8'hFF    // wrong end byte, dropped
  };

  typedef struct {
    kind_t      kind;
    logic [7:0] tx;
    logic       last;
    logic [7:0] acked;
  } out_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_START_BYTE;
  logic [7:0]  cfg_data = 8'h00;

  // Stimulus and expectations
  logic [7:0] rx_stream[$];      // bytes still to be offered, front is next
  out_item_t  awaited_items[$];  // predicted results, oldest first
  out_item_t  want;
  int         errors = 0;
  int         cycles = 0;
  bit         in_taken = 1'b0;   // front byte accepted at the last rising edge
  bit         calm = 1'b0;       // no random idling on either side
  bit         hold_req = 1'b0;   // ask the receiver for one long hold-off
  int         hold_left = 0;

  // Shadow configuration
  logic [7:0] start_b = 8'h02;
  logic [7:0] end_b   = 8'h03;
  logic [7:0] ack_cmd = 8'h06;

  // Shadow parser state
  phase_t     ph = PH_WAIT;
  logic [7:0] fr_cmd = 8'h00;
  logic [7:0] fr_len = 8'h00;
  logic [7:0] fr_seen = 8'h00;
  logic [7:0] fr_xor = 8'h00;
  logic       sum_ok = 1'b0;
  logic [7:0] fr_first = 8'h00;
  logic [7:0] acks = 8'h00;

  xor_framed_packet_ack_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [7:0] rx_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [7:0] tx_byte, [15:8] acked_count
    .out_tuser  (out_tuser),    // [1:0] kind
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  //--------------------------------------------------------------------------
  // Prediction
  //--------------------------------------------------------------------------
  task automatic push_result(input kind_t k, input logic [7:0] tx, input logic last);
    out_item_t r;
    r.kind  = k;
    r.tx    = tx;
    r.last  = last;
    r.acked = acks;
    awaited_items.push_back(r);
  endtask

  // Six-byte reply frame: start, command, length 1, flag, checksum, end.
  task automatic push_reply(input logic flag);
    push_result(KIND_TX, start_b, 1'b0);
    push_result(KIND_TX, ack_cmd, 1'b0);
    push_result(KIND_TX, REPLY_LEN_BYTE, 1'b0);
    push_result(KIND_TX, {7'd0, flag}, 1'b0);
    push_result(KIND_TX, ack_cmd ^ REPLY_LEN_BYTE ^ {7'd0, flag}, 1'b0);
    push_result(KIND_TX, end_b, 1'b1);
  endtask

  // Advance the shadow parser by one accepted byte and queue what it causes.
  task automatic parse_rx_byte(input logic [7:0] b);
    case (ph)
      PH_CMD: begin
        fr_cmd = b;
        fr_xor = b;
        ph     = PH_LEN;
      end
      PH_LEN: begin
        fr_len   = b;
        fr_xor   = fr_xor ^ b;
        fr_seen  = 8'h00;
        fr_first = 8'h00;
        if (b > MAX_PAYLOAD) begin
          ph = PH_WAIT;        // overlong: drop without a trace
        end else if (b == 8'h00) begin
          ph = PH_SUM;
        end else begin
          ph = PH_PAY;
        end
      end
      PH_PAY: begin
        if (fr_seen == 8'h00) fr_first = b;
        fr_xor  = fr_xor ^ b;
        fr_seen = fr_seen + 8'd1;
        if (fr_seen >= fr_len) ph = PH_SUM;
      end
      PH_SUM: begin
        sum_ok = (b == fr_xor);
        ph     = PH_END;
      end
      PH_END: begin
        ph = PH_WAIT;
        if (b == end_b) begin
          if (!sum_ok) begin
            push_reply(1'b0);
          end else if (fr_cmd == ack_cmd) begin
            // zero-length ack frames have no first byte, so they are nacks
            if (fr_len != 8'h00 && fr_first == 8'h01) begin
              acks = acks + 8'd1;
              push_result(KIND_ACK, 8'h00, 1'b1);
            end else begin
              push_result(KIND_NACK, 8'h00, 1'b1);
            end
          end else begin
            push_reply(1'b1);
          end
        end
      end
      default: begin
        if (b == start_b) begin
          fr_xor = 8'h00;
          ph     = PH_CMD;
        end else begin
          ph = PH_WAIT;
        end
      end
    endcase
  endtask

  //--------------------------------------------------------------------------
  // Input side: accept at the rising edge, drive at the falling edge
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      parse_rx_byte(in_tdata);
      void'(rx_stream.pop_front());
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      // offered byte is gone (or nothing was offered): pick the next move
      if (rx_stream.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= rx_stream[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  //--------------------------------------------------------------------------
  // Output side: random stalls, one long hold-off on request
  //--------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 20);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_items.size() == 0) begin
        $display("%0t: result with nothing expected: kind %0d byte %02h last %0b count %02h",
                 $time, out_tuser, out_tdata[7:0], out_tlast, out_tdata[15:8]);
        errors++;
      end else begin
        want = awaited_items.pop_front();
        if (out_tuser !== want.kind) begin
          $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, out_tuser);
          errors++;
        end
        if (out_tdata[7:0] !== want.tx) begin
          $display("%0t: tx_byte mismatch, expected %02h, got %02h",
                   $time, want.tx, out_tdata[7:0]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, out_tlast);
          errors++;
        end
        if (out_tdata[15:8] !== want.acked) begin
          $display("%0t: acked_count mismatch, expected %02h, got %02h",
                   $time, want.acked, out_tdata[15:8]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus
  //--------------------------------------------------------------------------
  // Register writes go out back to back; the caller drops cfg_we afterwards.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_START_BYTE:  start_b = val;
      CFG_END_BYTE:    end_b   = val;
      CFG_ACK_COMMAND: ack_cmd = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] a);
    write_reg(CFG_START_BYTE, s);
    write_reg(CFG_END_BYTE, e);
    write_reg(CFG_ACK_COMMAND, a);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random run: mostly well-formed frames, the rest broken frames and noise.
  task automatic queue_random_run();
    int         r;
    int         n;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r >= 85) begin
      n = $urandom_range(3, 1);
      repeat (n) rx_stream.push_back(8'($urandom));
      return;
    end
    cmd = ($urandom_range(99) < 40) ? ack_cmd : 8'($urandom);
    rx_stream.push_back(start_b);
    rx_stream.push_back(cmd);
    if (r >= 78) begin
      rx_stream.push_back(8'($urandom_range(255, 121)));   // overlong length
      return;
    end
    // the full 120-byte payload only now and then
    len = ($urandom_range(49) == 0) ? MAX_PAYLOAD : 8'($urandom_range(6));
    rx_stream.push_back(len);
    sum = cmd ^ len;
    for (int k = 0; k < len; k++) begin
      b = (k == 0 && $urandom_range(99) < 60) ? 8'h01 : 8'($urandom);
      sum = sum ^ b;
      rx_stream.push_back(b);
    end
    if (r >= 55 && r < 70) sum = sum ^ 8'($urandom_range(255, 1));
    rx_stream.push_back(sum);
    rx_stream.push_back((r >= 70) ? (end_b ^ 8'($urandom_range(255, 1))) : end_b);
  endtask

  task automatic queue_random(input int count);
    int target;
    target = rx_stream.size() + count;
    while (rx_stream.size() < target) queue_random_run();
  endtask

  // Block idle: all bytes taken, all results seen, dropped frames drained.
  task automatic settle();
    wait (rx_stream.size() == 0);
    wait (awaited_items.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed opening under the reset configuration
    for (int k = OPENING_LEN - 1; k >= 0; k--) rx_stream.push_back(OPENING[8*k +: 8]);
    settle();

    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    queue_random(60);
    settle();

    // low extremes for start, high for end and ack command; no idling here
    set_config(8'h00, 8'hFF, 8'hFF);
    calm = 1'b1;
    queue_random(55);
    settle();
    calm = 1'b0;

    set_config(8'hFF, 8'h00, 8'h00);
    queue_random(55);
    settle();

    set_config(8'($urandom), 8'($urandom), 8'($urandom));
    queue_random(70);
    settle();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/xfpar_pkg.sv
rtl/xfpar_parser.sv
rtl/xor_framed_packet_ack_receiver.sv
bench/tb.sv
